// ===== rtl/ntpc_pkg.sv =====
package ntpc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 17;
  localparam int CALC_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int CNT_W        = $clog2(CALC_STEPS + 1);
  localparam int CW           = 20;

  localparam logic signed [15:0] ANG_PI      = 16'sd12868;
  localparam logic signed [15:0] ANG_TWO_PI  = 16'sd25736;
  localparam logic signed [15:0] ANG_HALF_PI = 16'sd6434;

  localparam logic [1:0] CFG_LINEAR_GAIN   = 2'd0;
  localparam logic [1:0] CFG_ANGULAR_GAIN  = 2'd1;
  localparam logic [1:0] CFG_NEAREST_FIRST = 2'd2;
  localparam logic [1:0] CFG_REACH_RADIUS  = 2'd3;

  typedef enum logic [1:0] {
    OP_POSE = 2'd0,
    OP_CAND = 2'd1,
    OP_TICK = 2'd2,
    OP_RSVD = 2'd3
  } ntpc_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CALC1, S_SCAN, S_PREP, S_CALC2, S_LOCK, S_ERR, S_MUL
  } ntpc_state_t;

  typedef struct packed {
    logic capture;
    logic pose_wr;
    logic calc_start;
    logic calc_sel_lock;
    logic calc_step;
    logic scan_upd;
    logic lock_upd;
    logic err_ld;
    logic out_ld;
  } ntpc_cmd_t;

  typedef struct packed {
    ntpc_op_t op;
    logic     calc_done;
    logic     tick_ok;
    logic     need_lock;
    logic     out_busy;
  } ntpc_stat_t;

  function automatic logic [11:0] atan_q12(input logic [4:0] i);
    logic [11:0] v;
    case (i)
      5'd0:    v = 12'd3217;
      5'd1:    v = 12'd1899;
      5'd2:    v = 12'd1003;
      5'd3:    v = 12'd509;
      5'd4:    v = 12'd256;
      5'd5:    v = 12'd128;
      5'd6:    v = 12'd64;
      5'd7:    v = 12'd32;
      5'd8:    v = 12'd16;
      5'd9:    v = 12'd8;
      5'd10:   v = 12'd4;
      5'd11:   v = 12'd2;
      5'd12:   v = 12'd1;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ntpc_if.sv =====
interface ntpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [14:0] heading;
  logic [7:0]         candidate_id;
  logic               last_in_list;
  modport source (output valid, command, pos_x, pos_y, heading, candidate_id, last_in_list,
                  input ready);
  modport sink   (input valid, command, pos_x, pos_y, heading, candidate_id, last_in_list,
                  output ready);
endinterface

interface ntpc_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        linear_speed;
  logic signed [15:0] angular_speed;
  logic               reached;
  logic [7:0]         reached_id;
  modport source (output valid, linear_speed, angular_speed, reached, reached_id,
                  input ready);
  modport sink   (input valid, linear_speed, angular_speed, reached, reached_id,
                  output ready);
endinterface

// ===== rtl/ntpc_ctrl.sv =====
module ntpc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ntpc_pkg::ntpc_stat_t  stat,
  output ntpc_pkg::ntpc_cmd_t   cmd
);

  ntpc_pkg::ntpc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntpc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ntpc_pkg::S_IDLE:     if (in_valid) state_nxt = ntpc_pkg::S_DISPATCH;
      ntpc_pkg::S_DISPATCH: begin
        case (stat.op)
          ntpc_pkg::OP_CAND: state_nxt = ntpc_pkg::S_CALC1;
          ntpc_pkg::OP_TICK: state_nxt = stat.tick_ok ? ntpc_pkg::S_ERR : ntpc_pkg::S_IDLE;
          default:           state_nxt = ntpc_pkg::S_IDLE;
        endcase
      end
      ntpc_pkg::S_CALC1:    if (stat.calc_done) state_nxt = ntpc_pkg::S_SCAN;
      ntpc_pkg::S_SCAN:     state_nxt = ntpc_pkg::S_PREP;
      ntpc_pkg::S_PREP:     state_nxt = stat.need_lock ? ntpc_pkg::S_CALC2 : ntpc_pkg::S_IDLE;
      ntpc_pkg::S_CALC2:    if (stat.calc_done) state_nxt = ntpc_pkg::S_LOCK;
      ntpc_pkg::S_LOCK:     state_nxt = ntpc_pkg::S_IDLE;
      ntpc_pkg::S_ERR:      state_nxt = ntpc_pkg::S_MUL;
      ntpc_pkg::S_MUL:      if (!stat.out_busy) state_nxt = ntpc_pkg::S_IDLE;
      default:              state_nxt = ntpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ntpc_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ntpc_pkg::S_DISPATCH: begin
        cmd.pose_wr    = (stat.op == ntpc_pkg::OP_POSE);
        cmd.calc_start = (stat.op == ntpc_pkg::OP_CAND);
      end
      ntpc_pkg::S_CALC1: cmd.calc_step = !stat.calc_done;
      ntpc_pkg::S_SCAN:  cmd.scan_upd  = 1'b1;
      ntpc_pkg::S_PREP: begin
        cmd.calc_start    = stat.need_lock;
        cmd.calc_sel_lock = 1'b1;
      end
      ntpc_pkg::S_CALC2: cmd.calc_step = !stat.calc_done;
      ntpc_pkg::S_LOCK:  cmd.lock_upd  = 1'b1;
      ntpc_pkg::S_ERR:   cmd.err_ld    = 1'b1;
      ntpc_pkg::S_MUL:   cmd.out_ld    = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== rtl/ntpc_datapath.sv =====
module ntpc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  ntpc_in_if.sink              in_ch,
  ntpc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  ntpc_pkg::ntpc_cmd_t  cmd,
  output ntpc_pkg::ntpc_stat_t stat
);

  // Configuration registers.
  logic [15:0] lin_gain_r, ang_gain_r;
  logic        nearest_r;
  logic [14:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_gain_r <= 16'd256;
      ang_gain_r <= 16'd256;
      nearest_r  <= 1'b0;
      radius_r   <= 15'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        ntpc_pkg::CFG_LINEAR_GAIN:   lin_gain_r <= cfg_data;
        ntpc_pkg::CFG_ANGULAR_GAIN:  ang_gain_r <= cfg_data;
        ntpc_pkg::CFG_NEAREST_FIRST: nearest_r  <= cfg_data[0];
        ntpc_pkg::CFG_REACH_RADIUS:  radius_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  ntpc_pkg::ntpc_op_t op_r;
  logic signed [15:0] px_r, py_r;
  logic signed [14:0] hd_r;
  logic [7:0]         id_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= ntpc_pkg::OP_RSVD;
    end else if (cmd.capture) begin
      op_r <= ntpc_pkg::ntpc_op_t'(in_ch.command);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r   <= in_ch.pos_x;
      py_r   <= in_ch.pos_y;
      hd_r   <= in_ch.heading;
      id_r   <= in_ch.candidate_id;
      last_r <= in_ch.last_in_list;
    end
  end

  // Pose, target and scan state.
  logic signed [15:0] own_x_r, own_y_r, tgt_x_r, tgt_y_r, best_x_r, best_y_r;
  logic signed [15:0] lk_x_r, lk_y_r;
  logic signed [14:0] own_hd_r, tgt_brg_r;
  logic [15:0]        tgt_dist_r, best_dist_r;
  logic [7:0]         tgt_id_r, best_id_r, lk_id_r;
  logic               pose_valid_r, locked_r, at_start_r, need_lock_r;

  // Shared distance and bearing unit.
  logic [33:0]           n_r, res_r;
  logic [32:0]           bit_r;
  logic signed [ntpc_pkg::CW-1:0] cx_r, cy_r;
  logic signed [15:0]    z_r;
  logic                  zero_r;
  logic [ntpc_pkg::CNT_W-1:0] cnt_r;

  logic signed [15:0] op_x, op_y, lock_x, lock_y;
  logic [7:0]         lock_id;
  logic signed [16:0] dx, dy;
  logic [15:0]        dist_sat;
  logic signed [14:0] brg_clamp;

  always_comb begin
    if (nearest_r) begin
      lock_x  = locked_r ? tgt_x_r  : best_x_r;
      lock_y  = locked_r ? tgt_y_r  : best_y_r;
      lock_id = locked_r ? tgt_id_r : best_id_r;
    end else begin
      lock_x  = px_r;
      lock_y  = py_r;
      lock_id = id_r;
    end
    op_x = cmd.calc_sel_lock ? lock_x : px_r;
    op_y = cmd.calc_sel_lock ? lock_y : py_r;
    dx   = 17'(op_x) - 17'(own_x_r);
    dy   = 17'(op_y) - 17'(own_y_r);
    dist_sat = (res_r > 34'd65535) ? 16'hFFFF : res_r[15:0];
    if (zero_r)              brg_clamp = '0;
    else if (z_r > 16'sd16383)  brg_clamp = 15'sd16383;
    else if (z_r < -16'sd16384) brg_clamp = -15'sd16384;
    else                     brg_clamp = z_r[14:0];
  end

  logic [34:0] trial;
  assign trial = 35'(res_r) + 35'(bit_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_start) begin
      n_r    <= $unsigned(34'(dx) * 34'(dx)) + $unsigned(34'(dy) * 34'(dy));
      res_r  <= '0;
      bit_r  <= 33'd1 << 32;
      cnt_r  <= '0;
      zero_r <= (dx == 17'sd0) && (dy == 17'sd0);
      if (dx < 0) begin
        if (dy >= 0) begin
          cx_r <= ntpc_pkg::CW'(dy);
          cy_r <= -ntpc_pkg::CW'(dx);
          z_r  <= ntpc_pkg::ANG_HALF_PI;
        end else begin
          cx_r <= -ntpc_pkg::CW'(dy);
          cy_r <= ntpc_pkg::CW'(dx);
          z_r  <= -ntpc_pkg::ANG_HALF_PI;
        end
      end else begin
        cx_r <= ntpc_pkg::CW'(dx);
        cy_r <= ntpc_pkg::CW'(dy);
        z_r  <= '0;
      end
    end else if (cmd.calc_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (bit_r != '0) begin
        if ({1'b0, n_r} >= trial) begin
          n_r   <= n_r - trial[33:0];
          res_r <= (res_r >> 1) + 34'(bit_r);
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      if (32'(cnt_r) < ntpc_pkg::CORDIC_STEPS) begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + (cy_r >>> cnt_r);
          cy_r <= cy_r - (cx_r >>> cnt_r);
          z_r  <= z_r + $signed({4'b0, ntpc_pkg::atan_q12(5'(cnt_r))});
        end else begin
          cx_r <= cx_r - (cy_r >>> cnt_r);
          cy_r <= cy_r + (cx_r >>> cnt_r);
          z_r  <= z_r - $signed({4'b0, ntpc_pkg::atan_q12(5'(cnt_r))});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_start && cmd.calc_sel_lock) begin
      lk_x_r  <= lock_x;
      lk_y_r  <= lock_y;
      lk_id_r <= lock_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_x_r      <= '0;
      own_y_r      <= '0;
      own_hd_r     <= '0;
      pose_valid_r <= 1'b0;
      locked_r     <= 1'b0;
      tgt_x_r      <= '0;
      tgt_y_r      <= '0;
      tgt_id_r     <= '0;
      tgt_dist_r   <= '0;
      tgt_brg_r    <= '0;
      best_dist_r  <= '0;
      best_x_r     <= '0;
      best_y_r     <= '0;
      best_id_r    <= '0;
      at_start_r   <= 1'b1;
      need_lock_r  <= 1'b0;
    end else begin
      if (cmd.pose_wr) begin
        own_x_r      <= px_r;
        own_y_r      <= py_r;
        own_hd_r     <= hd_r;
        pose_valid_r <= 1'b1;
      end
      if (cmd.scan_upd) begin
        if (at_start_r || (dist_sat < best_dist_r)) begin
          best_dist_r <= dist_sat;
          best_x_r    <= px_r;
          best_y_r    <= py_r;
          best_id_r   <= id_r;
        end
        at_start_r  <= last_r;
        need_lock_r <= nearest_r ? last_r : at_start_r;
      end
      if (cmd.lock_upd) begin
        tgt_x_r    <= lk_x_r;
        tgt_y_r    <= lk_y_r;
        tgt_id_r   <= lk_id_r;
        tgt_dist_r <= dist_sat;
        tgt_brg_r  <= brg_clamp;
        locked_r   <= 1'b1;
      end
    end
  end

  // Heading error, wrapped into [-pi, pi).
  logic signed [16:0] e_raw, e_wrap;
  logic signed [15:0] err_r;
  always_comb begin
    e_raw = 17'(tgt_brg_r) - 17'(own_hd_r) + 17'(ntpc_pkg::ANG_PI);
    if (e_raw < 0)                              e_wrap = e_raw + 17'(ntpc_pkg::ANG_TWO_PI);
    else if (e_raw >= 17'(ntpc_pkg::ANG_TWO_PI)) e_wrap = e_raw - 17'(ntpc_pkg::ANG_TWO_PI);
    else                                        e_wrap = e_raw;
  end

  always_ff @(posedge clk) begin
    if (cmd.err_ld) err_r <= 16'(e_wrap - 17'(ntpc_pkg::ANG_PI));
  end

  // Speed products and the output register.
  logic [31:0]        lin_prod;
  logic signed [32:0] ang_prod;
  logic signed [24:0] ang_sh;
  logic [14:0]        lin_sat;
  logic signed [15:0] ang_sat;
  logic               reached;

  always_comb begin
    lin_prod = lin_gain_r * tgt_dist_r;
    ang_prod = $signed({1'b0, ang_gain_r}) * err_r;
    ang_sh   = 25'(ang_prod >>> 8);
    lin_sat  = (lin_prod[31:8] > 24'd32767) ? 15'h7FFF : lin_prod[22:8];
    if (ang_sh > 25'sd32767)       ang_sat = 16'sh7FFF;
    else if (ang_sh < -25'sd32768) ang_sat = -16'sh8000;
    else                           ang_sat = ang_sh[15:0];
    reached = (tgt_dist_r <= {1'b0, radius_r});
  end

  logic               out_valid_r;
  logic [14:0]        out_lin_r;
  logic signed [15:0] out_ang_r;
  logic               out_reached_r;
  logic [7:0]         out_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_lin_r     <= reached ? '0 : lin_sat;
      out_ang_r     <= reached ? '0 : ang_sat;
      out_reached_r <= reached;
      out_id_r      <= reached ? tgt_id_r : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.linear_speed  = out_lin_r;
  assign out_ch.angular_speed = out_ang_r;
  assign out_ch.reached       = out_reached_r;
  assign out_ch.reached_id    = out_id_r;

  assign stat.op        = op_r;
  assign stat.calc_done = (32'(cnt_r) == ntpc_pkg::CALC_STEPS);
  assign stat.tick_ok   = pose_valid_r && locked_r;
  assign stat.need_lock = need_lock_r;
  assign stat.out_busy  = out_valid_r && !out_ch.ready;

endmodule

// ===== rtl/nearest_target_pursuit_controller_core.sv =====
// Go-to-goal pursuit controller that locks onto one target of a candidate list.
// Input channel (in_ch): one item per handshake, valid and ready both high at a
// rising edge. A pose update (command 0) is written in the dispatch state. A
// candidate element (command 1) runs the shared square-root and CORDIC unit,
// then the scan and prep states; when it locks a target, the unit runs a
// second pass before the lock state. A control tick (command 2) forms the
// heading error and yields one item on the result channel (out_ch), or none
// when no pose or no target is held yet. Only one input item is in work at a
// time; in_ch.ready is high whenever the sequencer is idle.
// The result sits in an output register, so the block takes further pose and
// candidate items while the receiver stalls; a later tick waits for the output
// register to empty before it writes.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user while
// idle only; the block does not enforce it. Synchronous active-low reset restores
// register defaults, clears pose and lock, marks the next candidate as a list start.
module nearest_target_pursuit_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  ntpc_in_if.sink     in_ch,
  ntpc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ntpc_pkg::ntpc_cmd_t  cmd;
  ntpc_pkg::ntpc_stat_t stat;
  logic                 in_ready;

  assign in_ch.ready = in_ready;

  // The sequencer steps through the phases of one item.
  ntpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds all data, the shared geometry unit and the output register.
  ntpc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // A new result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> !(out_ch.valid && !out_ch.ready))
    else $error("result register overwritten");

  // A reached result carries zero speeds.
  a_reached_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.reached) |-> (out_ch.linear_speed == '0 &&
                                          out_ch.angular_speed == '0))
    else $error("reached result with nonzero speed");

  // The input stays blocked while the geometry unit iterates.
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_step |-> !in_ch.ready)
    else $error("input accepted during calculation");

endmodule
